// ===== sv/msm_pkg.sv =====
`default_nettype none

package msm_pkg;

  // Fixed field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int MASK_W     = 6;
  localparam int VOLUME_W   = 16;
  localparam int STEP_W     = 24;
  localparam int SAMPLE_W   = 16;
  localparam int SINE_W     = 15;
  localparam int FRAC_SHIFT = 15;

  // Parameter defaults
  localparam int VOICE_COUNT_DEF      = 6;
  localparam int PHASE_BITS_DEF       = 24;
  localparam int SINE_TABLE_DEPTH_DEF = 1024;

  localparam logic [VOLUME_W-1:0] VOLUME_RESET = 16'd1000;

  // pi/2 in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Register map
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_MASK = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VOLUME      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_BASE   = 3'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_VOICE,
    ST_DRAIN,
    ST_MULT,
    ST_EMIT
  } msm_state_t;

  typedef struct packed {
    logic phase_en;   // advance voice, issue table lookup
    logic acc_clr;    // clear accumulator
    logic last_load;  // capture end-of-buffer flag
    logic mul_en;     // apply volume
    logic out_load;   // scale, saturate, fill output register
  } msm_cmd_t;

  typedef struct packed {
    logic out_stall;  // output register full and not taken
  } msm_status_t;

endpackage

`default_nettype wire

// ===== sv/msm_sine_rom.sv =====
`default_nettype none

module msm_sine_rom
  import msm_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                                   clk,
  input  wire logic [$clog2(SINE_TABLE_DEPTH+1)-1:0]  addr,
  output logic      [SINE_W-1:0]                      data
);

  typedef logic [SINE_W-1:0] rom_t [0:SINE_TABLE_DEPTH];

  localparam longint unsigned HALF_DEPTH = 64'(SINE_TABLE_DEPTH / 2);
  localparam longint unsigned ONE_Q30    = 64'd1 << 30;

  // Divide one Taylor term by (2n)(2n+1)
  function automatic longint unsigned taylor_div(input longint unsigned t, input int n);
    longint unsigned r;
    case (n)
      1:       r = t / 64'd6;
      2:       r = t / 64'd20;
      3:       r = t / 64'd42;
      4:       r = t / 64'd72;
      5:       r = t / 64'd110;
      6:       r = t / 64'd156;
      7:       r = t / 64'd210;
      8:       r = t / 64'd272;
      9:       r = t / 64'd342;
      10:      r = t / 64'd420;
      default: r = t;
    endcase
    return r;
  endfunction

  // Quarter-wave table, Taylor series to x^21 in Q2.30, rounded to Q1.15
  function automatic rom_t build_rom();
    rom_t            tab;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned e;
    longint          sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30 + HALF_DEPTH) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 10; n++) begin
        term = taylor_div((term * x2) >> 30, n);
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
        sum = longint'(ONE_Q30);
      end
      e = (64'(sum) * 64'd32767 + (ONE_Q30 >> 1)) >> 30;
      if (e > 64'd32767) begin
        e = 64'd32767;
      end
      tab[k] = SINE_W'(e);
    end
    return tab;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

`default_nettype wire

// ===== sv/msm_datapath.sv =====
`default_nettype none

module msm_datapath
  import msm_pkg::*;
#(
  parameter int VOICE_COUNT      = VOICE_COUNT_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF,
  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // control
  input  wire msm_cmd_t              cmd,
  input  wire logic [VIW-1:0]        voice_idx,
  output msm_status_t                status,
  // streams
  input  wire logic                  buffer_last,
  input  wire logic                  out_tready,
  output logic                       out_tvalid,
  output logic [2*SAMPLE_W-1:0]      out_tdata,
  output logic                       out_tuser,
  output logic                       out_tlast
);

  localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int TAB_L  = AW - 1;
  localparam int ACC_W  = SAMPLE_W + $clog2(VOICE_COUNT);
  localparam int PROD_W = ACC_W + VOLUME_W + 1;
  localparam int SC_W   = PROD_W - FRAC_SHIFT;

  localparam logic signed [SC_W-1:0]   SAT_MAX = SC_W'(32767);
  localparam logic signed [SC_W-1:0]   SAT_MIN = SC_W'(-32768);
  localparam logic signed [PROD_W-1:0] TRUNC_BIAS = PROD_W'((1 << FRAC_SHIFT) - 1);

  // Configuration registers
  logic [VOICE_COUNT-1:0] mask_r;
  logic [VOLUME_W-1:0]    volume_r;
  logic [STEP_W-1:0]      step_r [VOICE_COUNT];

  // Voice phase state
  logic [PHASE_BITS-1:0]  phase_r [VOICE_COUNT];

  // Lookup pipeline
  logic [AW-1:0]          rom_addr_r;
  logic                   s1_neg_r;
  logic                   s1_vld_r;
  logic                   s2_neg_r;
  logic                   s2_vld_r;
  logic [SINE_W-1:0]      rom_q;

  logic signed [ACC_W-1:0]  acc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic                     last_r;

  logic                  out_vld_r;
  logic [SAMPLE_W-1:0]   sample_r;
  logic                  clip_r;
  logic                  olast_r;

  logic [PHASE_BITS-1:0] phase_nxt;
  logic [1:0]            quad;
  logic [TAB_L-1:0]      tab_idx;
  logic [AW-1:0]         rom_addr_nxt;
  logic signed [ACC_W-1:0]  sine_ext;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [PROD_W-1:0] rnd;
  logic signed [SC_W-1:0]   scaled;
  logic [SAMPLE_W-1:0]   sample_nxt;
  logic                  clip_nxt;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r   <= '0;
      volume_r <= VOLUME_RESET;
      for (int i = 0; i < VOICE_COUNT; i++) begin
        step_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ACTIVE_MASK: mask_r   <= cfg_data[VOICE_COUNT-1:0];
        REG_VOLUME:      volume_r <= cfg_data[VOLUME_W-1:0];
        default: begin
          for (int i = 0; i < VOICE_COUNT; i++) begin
            if (cfg_index == REG_STEP_BASE + CFG_IDX_W'(i)) begin
              step_r[i] <= cfg_data[STEP_W-1:0];
            end
          end
        end
      endcase
    end
  end

  // Phase advance and quarter-wave address
  always_comb begin
    phase_nxt = mask_r[voice_idx] ? phase_r[voice_idx] + PHASE_BITS'(step_r[voice_idx])
                                  : '0;
    quad      = phase_nxt[PHASE_BITS-1 -: 2];
    tab_idx   = phase_nxt[PHASE_BITS-3 -: TAB_L];
    rom_addr_nxt = quad[0] ? AW'(SINE_TABLE_DEPTH) - AW'(tab_idx) : AW'(tab_idx);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        phase_r[i] <= '0;
      end
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (cmd.phase_en) begin
        phase_r[voice_idx] <= phase_nxt;
      end
      s1_vld_r <= cmd.phase_en;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    rom_addr_r <= rom_addr_nxt;
    s1_neg_r   <= quad[1];
    s2_neg_r   <= s1_neg_r;
  end

  msm_sine_rom #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_rom (
    .clk  (clk),
    .addr (rom_addr_r),
    .data (rom_q)
  );

  // Accumulate signed sine values
  always_comb begin
    sine_ext = signed'({{(ACC_W-SINE_W){1'b0}}, rom_q});
    acc_nxt  = acc_r + (s2_neg_r ? -sine_ext : sine_ext);
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (s2_vld_r) begin
      acc_r <= acc_nxt;
    end
    if (cmd.last_load) begin
      last_r <= buffer_last;
    end
    if (cmd.mul_en) begin
      prod_r <= acc_r * signed'({1'b0, volume_r});
    end
  end

  // Shift toward zero, then saturate
  always_comb begin
    rnd    = prod_r + (prod_r[PROD_W-1] ? TRUNC_BIAS : '0);
    scaled = signed'(rnd[PROD_W-1:FRAC_SHIFT]);
    if (scaled > SAT_MAX) begin
      sample_nxt = SAMPLE_W'(SAT_MAX);
      clip_nxt   = 1'b1;
    end else if (scaled < SAT_MIN) begin
      sample_nxt = SAMPLE_W'(SAT_MIN);
      clip_nxt   = 1'b1;
    end else begin
      sample_nxt = scaled[SAMPLE_W-1:0];
      clip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      sample_r <= sample_nxt;
      clip_r   <= clip_nxt;
      olast_r  <= last_r;
    end
  end

  assign status.out_stall = out_vld_r && !out_tready;

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {sample_r, sample_r};
  assign out_tuser  = clip_r;
  assign out_tlast  = olast_r;

endmodule

`default_nettype wire

// ===== sv/msm_ctrl.sv =====
`default_nettype none

module msm_ctrl
  import msm_pkg::*;
#(
  parameter int VOICE_COUNT = VOICE_COUNT_DEF,
  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire msm_status_t  status,
  output msm_cmd_t          cmd,
  output logic [VIW-1:0]    voice_idx
);

  localparam logic [VIW-1:0] LAST_VOICE = VIW'(VOICE_COUNT - 1);

  msm_state_t     state_r, state_nxt;
  logic [VIW-1:0] cnt_r, cnt_nxt;
  logic           drain_r, drain_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      drain_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drain_r <= drain_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    drain_nxt = drain_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cnt_nxt   = VIW'(1);
          drain_nxt = 1'b0;
          state_nxt = (VOICE_COUNT > 1) ? ST_VOICE : ST_DRAIN;
        end
      end
      ST_VOICE: begin
        cnt_nxt = cnt_r + VIW'(1);
        if (cnt_r == LAST_VOICE) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) begin
          state_nxt = ST_MULT;
        end
      end
      ST_MULT: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (!status.out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    voice_idx = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready     = 1'b1;
        cmd.phase_en  = in_tvalid;
        cmd.acc_clr   = in_tvalid;
        cmd.last_load = in_tvalid;
      end
      ST_VOICE: begin
        cmd.phase_en = 1'b1;
        voice_idx    = cnt_r;
      end
      ST_DRAIN: ;
      ST_MULT:  cmd.mul_en = 1'b1;
      ST_EMIT:  cmd.out_load = !status.out_stall;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/multi_voice_sine_mixer.sv =====
`default_nettype none

// Multi-voice sine mixer: each input transaction (one tick) yields one output
// transaction carrying a stereo sample. Per tick, every enabled voice adds its
// step to a PHASE_BITS phase accumulator (disabled voices are forced to phase
// zero) and reads a Q1.15 quarter-wave sine ROM; the signed values are summed,
// multiplied by volume, shifted right by 15 rounding toward zero and saturated
// to int16 (out_tuser flags saturation). Left and right carry the same sample.
// Timing: from the accept cycle, the voices go one per cycle through the single
// ROM port, followed by the registered lookup (address register, then ROM output
// register), the volume multiply and the scale/saturate step into the output
// register. The next tick is accepted as soon as the result is
// in the output register, even if it has not been taken yet. Config writes
// (cfg_index 0 mask, 1 volume, 2.. voice steps) are meant for idle time only.
// SINE_TABLE_DEPTH+1 entries of ROM are built at elaboration.

module multi_voice_sine_mixer
  import msm_pkg::*;
#(
  parameter int VOICE_COUNT      = VOICE_COUNT_DEF,
  parameter int PHASE_BITS       = PHASE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = SINE_TABLE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // config write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // tick stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [0] buffer_last, [7:1] zero
  // sample stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [2*SAMPLE_W-1:0]      out_tdata,  // [15:0] sample_left, [31:16] sample_right
  output logic                       out_tuser,  // [0] clipped
  output logic                       out_tlast   // last_out
);

  localparam int VIW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  msm_cmd_t       cmd;
  msm_status_t    status;
  logic [VIW-1:0] voice_idx;

  msm_ctrl #(
    .VOICE_COUNT (VOICE_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd),
    .voice_idx (voice_idx)
  );

  msm_datapath #(
    .VOICE_COUNT      (VOICE_COUNT),
    .PHASE_BITS       (PHASE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .cmd         (cmd),
    .voice_idx   (voice_idx),
    .status      (status),
    .buffer_last (in_tdata[0]),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

`default_nettype wire

// ===== sv/msm_checker.sv =====
`default_nettype none

module msm_port_checker
  import msm_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [2*SAMPLE_W-1:0] out_tdata,
  input wire logic                  out_tuser,
  input wire logic                  out_tlast
);

  // Stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("output changed while stalled");

  // One tick in flight: ready drops after an accepted transaction
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // Left and right carry the same sample
  a_mono: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[15:0] == out_tdata[31:16])
    else $error("left and right differ");

  // Clipped sample sits at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[15:0] == 16'h7fff || out_tdata[15:0] == 16'h8000)
    else $error("clip flag without rail value");

  // An accept made while the output is empty does not raise out_tvalid early
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> ##1 !out_tvalid)
    else $error("result too early");

endmodule

bind multi_voice_sine_mixer msm_port_checker u_msm_checker (.*);

`default_nettype wire
